### rtl/double_hash_table_insert_core_defines.svh
// Assertion macros shared by the hash table insert core.
`ifndef DOUBLE_HASH_TABLE_INSERT_CORE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_INSERT_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, held off during reset.
`define DHT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, held off during reset.
`define DHT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dht_pkg.sv
// Package: item types, status codes and default sizes of the hash table insert core.
package dht_pkg;

	localparam int TABLE_SIZE_DEF = 701;
	localparam int KEY_BITS_DEF   = 16;

	localparam int KEY_W    = 16;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_STORED   = 2'd3;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_STORE  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot;
	} dht_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   placed_slot;
		logic [SLOT_W-1:0]   probe_count;
	} dht_rsp_t;

endpackage

### rtl/dht_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module dht_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 701
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/double_hash_table_insert_core.sv
// Top level: open-addressing hash table insert with double hashing over a key RAM.
// A direct store or a zero key finishes in the cycle after acceptance; an insert forms the
// reciprocal residues on one shared multiplier in S_MUL_QM, S_MUL_PM, S_MUL_QM1 and S_MUL_PM1,
// then takes a RAM read (S_READ) and a check (S_CHECK) a probe, up to TABLE_SIZE probes when full.
// Throughput: busy drops with done, so the next item may be taken at the result edge. Reset
// clears the key RAM one slot a cycle, holding busy while it runs; no receiver stall.
`include "double_hash_table_insert_core_defines.svh"

module double_hash_table_insert_core #(
	parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF,
	parameter int KEY_BITS   = dht_pkg::KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dht_pkg::dht_req_t req,
	output logic              done,
	output dht_pkg::dht_rsp_t rsp
);

	import dht_pkg::*;

	localparam int AW  = $clog2(TABLE_SIZE);     // slot address width
	localparam int PW  = $clog2(TABLE_SIZE + 1); // passed-slot counter, holds TABLE_SIZE
	localparam int SH  = KEY_BITS + AW;          // reciprocal scale
	localparam int RW  = KEY_BITS + 2;           // reciprocal width
	localparam int OW  = (RW > AW) ? RW : AW;    // second multiplier operand
	localparam int XW  = KEY_BITS + OW;          // product width

	localparam logic [AW:0] MOD_M  = (AW+1)'(TABLE_SIZE);

	// Rounded-up reciprocals: floor(k * R >> SH) is the exact quotient for every key.
	localparam longint RCP_M_L  =
		((longint'(1) << SH) + longint'(TABLE_SIZE) - 1) / longint'(TABLE_SIZE);
	localparam longint RCP_M1_L =
		((longint'(1) << SH) + longint'(TABLE_SIZE) - 2) / longint'(TABLE_SIZE - 1);
	localparam logic [OW-1:0] RCP_M  = OW'(RCP_M_L);
	localparam logic [OW-1:0] RCP_M1 = OW'(RCP_M1_L);
	localparam logic [OW-1:0] DIV_M  = OW'(TABLE_SIZE);
	localparam logic [OW-1:0] DIV_M1 = OW'(TABLE_SIZE - 1);

	// Sequencer states
	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_MUL_QM  = 3'd2;
	localparam logic [2:0] S_MUL_PM  = 3'd3;
	localparam logic [2:0] S_MUL_QM1 = 3'd4;
	localparam logic [2:0] S_MUL_PM1 = 3'd5;
	localparam logic [2:0] S_READ    = 3'd6;
	localparam logic [2:0] S_CHECK   = 3'd7;

	logic [2:0]          state_q;
	logic [AW-1:0]       clr_q;
	logic [KEY_BITS-1:0] key_q;
	logic [XW-1:0]       prod_q;    // shared multiplier result
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       step_q;
	logic [PW-1:0]       passed_q;
	logic                done_q;
	dht_rsp_t            rsp_q;

	// Input decode
	logic [KEY_BITS-1:0] key_k;
	logic                accept;
	logic                slot_ok;

	// Shared multiplier and probe-advance arithmetic
	logic [KEY_BITS-1:0] mul_a;
	logic [OW-1:0]       mul_b;
	logic [XW-1:0]       mul_p;
	logic [KEY_BITS-1:0] quot;
	logic [AW-1:0]       rem_k;
	logic [AW:0]         pos_sum;
	logic [AW-1:0]       pos_nxt;
	logic [PW-1:0]       passed_inc;

	// RAM port
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [KEY_BITS-1:0] ram_rdata;

	// Keys are taken modulo 2^KEY_BITS.
	assign key_k   = KEY_BITS'(req.key);
	assign accept  = start && !busy;
	assign slot_ok = int'(req.slot) < TABLE_SIZE;
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign rsp     = rsp_q;

	// Residues by reciprocal: key * R gives the quotient, quotient * divisor is taken back
	// off the key. The remainder is below the divisor, so its low bits are the whole of it.
	always_comb begin
		mul_a = key_q;
		mul_b = RCP_M;
		unique case (state_q)
			S_MUL_PM: begin
				mul_a = quot;
				mul_b = DIV_M;
			end
			S_MUL_QM1: begin
				mul_b = RCP_M1;
			end
			S_MUL_PM1: begin
				mul_a = quot;
				mul_b = DIV_M1;
			end
			default: begin
				mul_b = RCP_M;
			end
		endcase
	end

	assign mul_p = XW'(mul_a) * XW'(mul_b);
	assign quot  = KEY_BITS'(prod_q >> SH);
	assign rem_k = AW'(XW'(key_q) - prod_q);

	// Advance the probe: pos + step stays below 2M, so one compare-subtract wraps it.
	assign pos_sum    = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_nxt    = (pos_sum >= MOD_M) ? AW'(pos_sum - MOD_M) : AW'(pos_sum);
	assign passed_inc = passed_q + PW'(1);

	// RAM write port: clearing sweep, direct store, or the insert itself.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = key_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				if (accept && req.func == FUNC_STORE && slot_ok) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(req.slot);
					ram_wdata = key_k;
				end
			end
			S_CHECK: begin
				ram_we = (ram_rdata == '0);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	dht_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(TABLE_SIZE)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					// Sweep the RAM to zero; every slot starts empty.
					clr_q <= clr_q + AW'(1);
					if (int'(clr_q) == TABLE_SIZE - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.func == FUNC_STORE || key_k == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_MUL_QM;
						end
					end
				end
				S_MUL_QM: begin
					state_q <= S_MUL_PM;
				end
				S_MUL_PM: begin
					state_q <= S_MUL_QM1;
				end
				S_MUL_QM1: begin
					state_q <= S_MUL_PM1;
				end
				S_MUL_PM1: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (ram_rdata == '0 || int'(passed_q) == TABLE_SIZE - 1) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q    <= key_k;
				passed_q <= '0;
				if (req.func == FUNC_STORE) begin
					rsp_q.status      <= ST_STORED;
					rsp_q.placed_slot <= slot_ok ? req.slot : '0;
					rsp_q.probe_count <= '0;
				end else begin
					rsp_q.status      <= ST_ZERO;
					rsp_q.placed_slot <= '0;
					rsp_q.probe_count <= '0;
				end
			end
			S_MUL_QM: begin
				prod_q <= mul_p;
			end
			S_MUL_PM: begin
				prod_q <= mul_p;
			end
			S_MUL_QM1: begin
				// Home slot of the probe sequence.
				pos_q  <= rem_k;
				prod_q <= mul_p;
			end
			S_MUL_PM1: begin
				prod_q <= mul_p;
			end
			S_READ: begin
				// Stride: key mod (M-1) plus one; prod_q holds its product through the walk.
				step_q <= rem_k + AW'(1);
			end
			S_CHECK: begin
				if (ram_rdata == '0) begin
					rsp_q.status      <= ST_INSERTED;
					rsp_q.placed_slot <= SLOT_W'(pos_q);
					rsp_q.probe_count <= SLOT_W'(passed_q);
				end else begin
					passed_q          <= passed_inc;
					pos_q             <= pos_nxt;
					rsp_q.status      <= ST_FULL;
					rsp_q.placed_slot <= '0;
					rsp_q.probe_count <= SLOT_W'(passed_inc);
				end
			end
			default: begin
				passed_q <= passed_q;
			end
		endcase
	end

	`DHT_ASSERT_IMP(a_pos_range, state_q == S_CHECK, int'(pos_q) < TABLE_SIZE,
		"probe position outside the table")
	`DHT_ASSERT_IMP(a_step_range, state_q == S_CHECK,
		step_q != '0 && int'(step_q) < TABLE_SIZE, "probe stride out of range")
	`DHT_ASSERT_NXT(a_done_src, !(state_q == S_IDLE || state_q == S_CHECK), !done,
		"result strobed from a state that cannot finish an item")
	`DHT_ASSERT_IMP(a_clear_quiet, state_q == S_CLEAR, busy && !done,
		"clearing pass not holding the block busy")

endmodule
